@@ src/lbte_pkg.sv @@
`timescale 1ns / 1ps
// Package: widths, constants, stage map and pipeline types of the log barrier term evaluator.
package lbte_pkg;

    // Field widths
    localparam int POS_W  = 32;
    localparam int OUT_W  = 48;
    localparam int EPS_W  = 31;
    localparam int OMAG_W = OUT_W - 1;

    localparam int S_TDATA_W = ((2 * POS_W + 2 + 7) / 8) * 8;
    localparam int M_TDATA_W = ((4 * OUT_W + 7) / 8) * 8;

    localparam logic [EPS_W-1:0]  EPS_RESET = EPS_W'(16777216);
    localparam logic [OMAG_W-1:0] OMAX      = {OMAG_W{1'b1}};

    // Arithmetic widths
    localparam int E3_W     = EPS_W + 2;      // e + 3d
    localparam int SQ_W     = 2 * EPS_W;      // d*d, g*g
    localparam int LOG_FB   = 28;             // log2 fraction bits
    localparam int LOG_W    = 5 + LOG_FB;     // Q5.28
    localparam int NL_W     = 33;             // -ln(d/e), Q.28
    localparam int EN_W     = 44;             // energy before clamp
    localparam int DQ_W     = 63;             // quotient width, also saturation value
    localparam int DD_W     = 62;             // divisor width
    localparam int DIV_FB   = 24;             // fraction bits produced by the divider
    localparam int DIV_HI_W = DIV_FB;         // bits of num above the quotient window
    localparam int S_W      = 60;             // q + 2*nl
    localparam logic [29:0]     LN2_Q30 = 30'd744261118;
    localparam logic [DQ_W-1:0] BIG     = {DQ_W{1'b1}};

    // Stage map (register index counted from the input register)
    localparam int LOG_LAT = 1 + LOG_FB;      // log2 unit latency
    localparam int DIV_LAT = 1 + DQ_W;        // divider latency
    localparam int C_BASE  = 4;               // stage of carry slot 0
    localparam int C_NL    = 2 + LOG_LAT + 3 - C_BASE;
    localparam int C_EN    = C_NL + 3;
    localparam int C_LAST  = DIV_LAT;
    localparam int NST     = C_BASE + DIV_LAT + 4;

    typedef struct packed {
        logic              act;
        logic              err;
        logic              fneg;
        logic              pair;
        logic [EPS_W-1:0]  g;
        logic [SQ_W-1:0]   gg;
        logic [NL_W-1:0]   nl;
        logic [EN_W-1:0]   en;
    } carry_t;

endpackage

@@ src/lbte_log2.sv @@
`timescale 1ns / 1ps
// Pipelined log2 unit: one squaring step per stage, Q5.28 result.
module lbte_log2
    import lbte_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [EPS_W-1:0]  x,
    output logic [LOG_W-1:0]  y
);

    logic [4:0]        n_reg    [0:LOG_FB];
    logic [EPS_W-1:0]  m_reg    [0:LOG_FB];
    logic [LOG_FB-1:0] frac_reg [0:LOG_FB];

    logic [4:0]        n0_w;
    logic [EPS_W-1:0]  m0_w;
    logic [EPS_W-1:0]  m_next [1:LOG_FB];
    logic              b_next [1:LOG_FB];

    // leading one and normalize to Q1.30
    always_comb begin
        n0_w = '0;
        for (int i = 0; i < EPS_W; i++) begin
            if (x[i]) begin
                n0_w = 5'(i);
            end
        end
        m0_w = x << (5'(EPS_W - 1) - n0_w);
    end

    always_comb begin
        logic [SQ_W-1:0] sq;
        logic [31:0]     t;
        for (int k = 1; k <= LOG_FB; k++) begin
            sq = SQ_W'(m_reg[k-1]) * SQ_W'(m_reg[k-1]);
            t  = sq[SQ_W-1:30];
            b_next[k] = t[31];
            m_next[k] = t[31] ? t[31:1] : t[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg[0]    <= n0_w;
            m_reg[0]    <= m0_w;
            frac_reg[0] <= '0;
            for (int k = 1; k <= LOG_FB; k++) begin
                n_reg[k]    <= n_reg[k-1];
                m_reg[k]    <= m_next[k];
                frac_reg[k] <= {frac_reg[k-1][LOG_FB-2:0], b_next[k]};
            end
        end
    end

    assign y = {n_reg[LOG_FB], frac_reg[LOG_FB]};

endmodule

@@ src/lbte_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider: floor(num * 2^24 / den), one quotient bit per stage, saturating.
module lbte_div
    import lbte_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [DQ_W-1:0]  num,
    input  logic [DD_W-1:0]  den,
    output logic [DQ_W-1:0]  quo
);

    logic [DD_W-1:0] rem_reg [0:DQ_W];
    logic [DD_W-1:0] den_reg [0:DQ_W];
    logic [DQ_W-1:0] xb_reg  [0:DQ_W];
    logic [DQ_W-1:0] q_reg   [0:DQ_W];
    logic            sat_reg [0:DQ_W];

    logic [DD_W-1:0] rem_next [1:DQ_W];
    logic            ge_next  [1:DQ_W];

    always_comb begin
        logic [DD_W:0] rt;
        for (int k = 1; k <= DQ_W; k++) begin
            rt = {rem_reg[k-1], xb_reg[k-1][DQ_W-1]};
            ge_next[k]  = rt >= {1'b0, den_reg[k-1]};
            rem_next[k] = ge_next[k] ? DD_W'(rt - {1'b0, den_reg[k-1]}) : rt[DD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= DD_W'(num[DQ_W-1:DQ_W-DIV_HI_W]);
            sat_reg[0] <= DD_W'(num[DQ_W-1:DQ_W-DIV_HI_W]) >= den;
            den_reg[0] <= den;
            xb_reg[0]  <= {num[DQ_W-DIV_HI_W-1:0], {DIV_FB{1'b0}}};
            q_reg[0]   <= '0;
            for (int k = 1; k <= DQ_W; k++) begin
                rem_reg[k] <= rem_next[k];
                sat_reg[k] <= sat_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                xb_reg[k]  <= xb_reg[k-1] << 1;
                q_reg[k]   <= {q_reg[k-1][DQ_W-2:0], ge_next[k]};
            end
        end
    end

    assign quo = sat_reg[DQ_W] ? BIG : q_reg[DQ_W];

endmodule

@@ src/log_barrier_term_eval.sv @@
`timescale 1ns / 1ps
// Pipeline: 72 stages from input accept to m_tvalid, plus the output register.
// Throughput: one item per cycle unless stalled; the 64-stage divider chain sets the depth.
// Stall: the pipeline halts only while its last stage holds an item the output cannot take.
// Reset: synchronous active-low aresetn clears stage valid bits and the output valid,
// and sets barrier_eps to 1.0 (16777216). cfg_ready is always high.
module log_barrier_term_eval
    import lbte_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // barrier_eps write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [EPS_W-1:0]     cfg_data,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // pos_first, pos_second, fixed_first, fixed_second
    input  logic [0:0]           s_tuser,  // cmd
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // energy_term, grad_first, grad_second, hess_term
    output logic [1:0]           m_tuser   // active, range_error
);

    // ------------------------------------------------------------------
    // Flow control: every stage moves together; a bubble in the last stage
    // lets the pipe keep moving while a result waits at the output.
    // ------------------------------------------------------------------
    logic              adv;
    logic [NST:1]      vld_reg;
    logic              m_valid_reg;
    logic [EPS_W-1:0]  eps_reg;

    assign adv       = !vld_reg[NST] || !m_valid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (cfg_valid) begin
            eps_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-1:1], s_tvalid};
        end
    end

    // ------------------------------------------------------------------
    // S1: input register
    // ------------------------------------------------------------------
    logic              s1_pair_reg, s1_f1_reg, s1_f2_reg;
    logic [POS_W-1:0]  s1_a_reg, s1_b_reg;
    logic [EPS_W-1:0]  s1_e_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_pair_reg <= s_tuser[0];
            s1_a_reg    <= s_tdata[POS_W-1:0];
            s1_b_reg    <= s_tdata[2*POS_W-1:POS_W];
            s1_f1_reg   <= s_tdata[2*POS_W];
            s1_f2_reg   <= s_tdata[2*POS_W+1];
            s1_e_reg    <= eps_reg;
        end
    end

    // ------------------------------------------------------------------
    // S1 -> S2: distance, activity, error, gradient sign
    // ------------------------------------------------------------------
    logic signed [POS_W:0] a_x, b_x, e_x, dr_w;
    logic [POS_W:0]        ad_w;
    logic                  act_w, err_w, fneg_w;
    logic [EPS_W-1:0]      d_w;

    always_comb begin
        a_x  = $signed({s1_a_reg[POS_W-1], s1_a_reg});
        b_x  = $signed({s1_b_reg[POS_W-1], s1_b_reg});
        e_x  = $signed({{(POS_W + 1 - EPS_W){1'b0}}, s1_e_reg});
        dr_w = b_x - a_x;
        ad_w = dr_w[POS_W] ? unsigned'(-dr_w) : unsigned'(dr_w);
        if (!s1_pair_reg) begin
            act_w  = !s1_f1_reg && (a_x <= e_x);
            err_w  = act_w && (a_x[POS_W] || (a_x == '0));
            d_w    = (act_w && !err_w) ? s1_a_reg[EPS_W-1:0] : '0;
            fneg_w = 1'b1;
        end else begin
            act_w  = !(s1_f1_reg && s1_f2_reg) && (ad_w < unsigned'(e_x));
            err_w  = act_w && (ad_w == '0);
            d_w    = ad_w[EPS_W-1:0];
            fneg_w = dr_w[POS_W];
        end
    end

    logic              s2_act_reg, s2_err_reg, s2_fneg_reg, s2_pair_reg;
    logic [EPS_W-1:0]  s2_e_reg, s2_d_reg, s2_g_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_act_reg  <= act_w;
            s2_err_reg  <= err_w;
            s2_fneg_reg <= fneg_w;
            s2_pair_reg <= s1_pair_reg;
            s2_e_reg    <= s1_e_reg;
            s2_d_reg    <= d_w;
            s2_g_reg    <= s1_e_reg - d_w;   // g = e - d
        end
    end

    // ------------------------------------------------------------------
    // S3: e + 3d, g*g, d*d
    // ------------------------------------------------------------------
    logic              s3_act_reg, s3_err_reg, s3_fneg_reg, s3_pair_reg;
    logic [EPS_W-1:0]  s3_d_reg, s3_g_reg;
    logic [E3_W-1:0]   s3_ep3d_reg;
    logic [SQ_W-1:0]   s3_gg_reg, s3_dd_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_act_reg  <= s2_act_reg;
            s3_err_reg  <= s2_err_reg;
            s3_fneg_reg <= s2_fneg_reg;
            s3_pair_reg <= s2_pair_reg;
            s3_d_reg    <= s2_d_reg;
            s3_g_reg    <= s2_g_reg;
            s3_ep3d_reg <= E3_W'(s2_e_reg) + E3_W'(s2_d_reg) + (E3_W'(s2_d_reg) << 1);
            s3_gg_reg   <= SQ_W'(s2_g_reg) * SQ_W'(s2_g_reg);
            s3_dd_reg   <= SQ_W'(s2_d_reg) * SQ_W'(s2_d_reg);
        end
    end

    // ------------------------------------------------------------------
    // S4: Hessian numerator g*(e+3d); divider operands
    // ------------------------------------------------------------------
    logic [DQ_W-1:0]  s4_hnum_reg;
    logic [DD_W-1:0]  s4_dd_reg;
    logic [EPS_W-1:0] s4_d_reg;
    logic [63:0]      hprod_w;

    assign hprod_w = 64'(s3_g_reg) * 64'(s3_ep3d_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_hnum_reg <= hprod_w[DQ_W-1:0];
            s4_dd_reg   <= s3_dd_reg;
            s4_d_reg    <= s3_d_reg;
        end
    end

    // ------------------------------------------------------------------
    // Side carry: flags, g, g*g, nl and energy ride along the divider.
    // Slot 0 is stage S4, slot C_LAST lines up with the divider outputs.
    // ------------------------------------------------------------------
    carry_t c_reg  [0:C_LAST];
    carry_t c_next [0:C_LAST];

    logic [LOG_W-1:0] le_w, ld_w;
    logic [LOG_W-1:0] diff_reg;
    logic [DQ_W-1:0]  prod_reg;
    logic [63:0]      elo_reg, ehi_reg;
    logic [95:0]      ensum_reg;
    logic [63:0]      nl_full_w;
    logic [95:0]      en_full_w;

    // log2(e) and log2(d), fed from S2, results at S31
    lbte_log2 u_log_e (.aclk(aclk), .en(adv), .x(s2_e_reg), .y(le_w));
    lbte_log2 u_log_d (.aclk(aclk), .en(adv), .x(s2_d_reg), .y(ld_w));

    assign nl_full_w = (64'(prod_reg) + (64'd1 << 29)) >> 30;
    assign en_full_w = (ensum_reg + (96'd1 << 51)) >> 52;

    always_comb begin
        c_next[0].act  = s3_act_reg;
        c_next[0].err  = s3_err_reg;
        c_next[0].fneg = s3_fneg_reg;
        c_next[0].pair = s3_pair_reg;
        c_next[0].g    = s3_g_reg;
        c_next[0].gg   = s3_gg_reg;
        c_next[0].nl   = '0;
        c_next[0].en   = '0;
        for (int i = 1; i <= C_LAST; i++) begin
            c_next[i] = c_reg[i-1];
            if (i == C_NL) begin
                c_next[i].nl = nl_full_w[NL_W-1:0];
            end
            if (i == C_EN) begin
                c_next[i].en = en_full_w[EN_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i <= C_LAST; i++) begin
                c_reg[i] <= c_next[i];
            end
            // -ln(d/e) chain: diff, times ln2, rounded in c_next[C_NL]
            diff_reg  <= (le_w > ld_w) ? (le_w - ld_w) : '0;
            prod_reg  <= DQ_W'(64'(diff_reg) * 64'(LN2_Q30));
            // energy chain: g*g split in two halves times nl
            elo_reg   <= 64'(c_reg[C_NL].gg[30:0]) * 64'(c_reg[C_NL].nl);
            ehi_reg   <= 64'(c_reg[C_NL].gg[SQ_W-1:31]) * 64'(c_reg[C_NL].nl);
            ensum_reg <= {1'b0, ehi_reg, 31'b0} + 96'(elo_reg);
        end
    end

    // ------------------------------------------------------------------
    // Dividers: q = g*2^28/d and h = g*(e+3d)*2^24/d^2, results at S68
    // ------------------------------------------------------------------
    logic [DQ_W-1:0] q_w, h_w;

    lbte_div u_div_q (
        .aclk (aclk),
        .en   (adv),
        .num  ({{(DQ_W - EPS_W - 4){1'b0}}, c_reg[0].g, 4'b0}),
        .den  (DD_W'(s4_d_reg)),
        .quo  (q_w)
    );

    lbte_div u_div_h (
        .aclk (aclk),
        .en   (adv),
        .num  (s4_hnum_reg),
        .den  (s4_dd_reg),
        .quo  (h_w)
    );

    // ------------------------------------------------------------------
    // P1..P4: gradient product, Hessian sum, clamping
    // ------------------------------------------------------------------
    carry_t           p1_c_reg, p2_c_reg, p3_c_reg;
    logic [S_W-1:0]   p1_s_reg;
    logic [DQ_W-1:0]  p1_h_reg, p2_h_reg, p3_h_reg;
    logic [60:0]      p2_tlo_reg, p2_thi_reg;
    logic [90:0]      p3_tsum_reg;
    logic [63:0]      hs_w;

    assign hs_w = 64'(h_w) + 64'((35'(c_reg[C_LAST].nl) + 35'd4) >> 3);

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_c_reg    <= c_reg[C_LAST];
            p1_s_reg    <= q_w[S_W-1:0] + S_W'({c_reg[C_LAST].nl, 1'b0});
            p1_h_reg    <= (hs_w > 64'(BIG)) ? BIG : hs_w[DQ_W-1:0];

            p2_c_reg    <= p1_c_reg;
            p2_h_reg    <= p1_h_reg;
            p2_tlo_reg  <= 61'(p1_c_reg.g) * 61'(p1_s_reg[29:0]);
            p2_thi_reg  <= 61'(p1_c_reg.g) * 61'(p1_s_reg[S_W-1:30]);

            p3_c_reg    <= p2_c_reg;
            p3_h_reg    <= p2_h_reg;
            p3_tsum_reg <= {p2_thi_reg, 30'b0} + 91'(p2_tlo_reg);
        end
    end

    // P4: round gradient, clamp magnitudes, apply special cases
    logic [91:0]       tr_w;
    logic [63:0]       tfull_w;
    logic [OMAG_W-1:0] tm_mag_w, en_mag_w, hm_mag_w;

    always_comb begin
        tr_w     = 92'(p3_tsum_reg) + (92'd1 << 27);
        tfull_w  = tr_w[91:28];
        tm_mag_w = (tfull_w > 64'(OMAX)) ? OMAX : tfull_w[OMAG_W-1:0];
        en_mag_w = (64'(p3_c_reg.en) > 64'(OMAX)) ? OMAX : OMAG_W'(p3_c_reg.en);
        hm_mag_w = (64'(p3_h_reg) > 64'(OMAX)) ? OMAX : p3_h_reg[OMAG_W-1:0];
        if (p3_c_reg.err) begin
            tm_mag_w = OMAX;
            en_mag_w = OMAX;
            hm_mag_w = OMAX;
        end
        if (!p3_c_reg.act) begin
            tm_mag_w = '0;
            en_mag_w = '0;
            hm_mag_w = '0;
        end
    end

    logic              p4_act_reg, p4_err_reg, p4_fneg_reg, p4_pair_reg;
    logic [OMAG_W-1:0] p4_tm_reg, p4_en_reg, p4_hm_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p4_act_reg  <= p3_c_reg.act;
            p4_err_reg  <= p3_c_reg.act && p3_c_reg.err;
            p4_fneg_reg <= p3_c_reg.fneg;
            p4_pair_reg <= p3_c_reg.pair;
            p4_tm_reg   <= tm_mag_w;
            p4_en_reg   <= en_mag_w;
            p4_hm_reg   <= hm_mag_w;
        end
    end

    // ------------------------------------------------------------------
    // Output register: sign the gradients
    // ------------------------------------------------------------------
    logic [OUT_W-1:0] tpos_w, tneg_w;
    logic [OUT_W-1:0] out_en_reg, out_g1_reg, out_g2_reg, out_hm_reg;
    logic [1:0]       out_user_reg;

    assign tpos_w = OUT_W'(p4_tm_reg);
    assign tneg_w = OUT_W'(0) - tpos_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && vld_reg[NST]) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && vld_reg[NST]) begin
            out_user_reg <= {p4_err_reg, p4_act_reg};
            out_en_reg   <= OUT_W'(p4_en_reg);
            out_hm_reg   <= OUT_W'(p4_hm_reg);
            out_g1_reg   <= p4_fneg_reg ? tneg_w : tpos_w;
            out_g2_reg   <= !p4_pair_reg ? '0 : (p4_fneg_reg ? tpos_w : tneg_w);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_user_reg;
    assign m_tdata  = M_TDATA_W'({out_hm_reg, out_g2_reg, out_g1_reg, out_en_reg});

endmodule

@@ src/lbte_check.sv @@
`timescale 1ns / 1ps
// Port checker for the log barrier term evaluator, bound to the top level.
module lbte_check
    import lbte_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [1:0]           m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // no result comes out of reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // range error only on an active term
    a_err_act: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("range_error without active");

    // inactive item carries all zero values
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0) && (m_tuser == '0))
        else $error("inactive item with nonzero values");

    // energy and Hessian are never negative
    a_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[OUT_W-1] && !m_tdata[4*OUT_W-1])
        else $error("negative energy or Hessian");

endmodule

bind log_barrier_term_eval lbte_check u_lbte_check (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Testbench for log_barrier_term_eval: random and directed items checked against a predictor.
module tb;
    import lbte_pkg::*;

    localparam logic CMD_FLOOR = 1'b0;
    localparam logic CMD_PAIR  = 1'b1;
    localparam longint unsigned BIGV = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int PIPE_LAT = 73;

    typedef struct packed {
        logic        act;
        logic        err;
        logic [47:0] en;
        logic [47:0] g1;
        logic [47:0] g2;
        logic [47:0] hs;
    } term_t;

    // barrier predictor and queue of pending results
    class barrier_board;
        longint unsigned eps;
        term_t pending[$];
        int errors;

        function new();
            eps = 64'd16777216;
            errors = 0;
        endfunction

        function longint unsigned sat_add(longint unsigned a, longint unsigned b);
            if (a > BIGV || b > BIGV - a) return BIGV;
            return a + b;
        endfunction

        // round half up of a*b / 2^s, saturating
        function longint unsigned mul_shr(longint unsigned a, longint unsigned b, int s);
            logic [127:0] p;
            p = 128'(a) * 128'(b) + (128'(1) << (s - 1));
            p = p >> s;
            if (p > 128'(BIGV)) return BIGV;
            return p[63:0];
        endfunction

        function longint unsigned div_frac(longint unsigned num, longint unsigned den, int fb);
            logic [127:0] r;
            if (den == 0) return BIGV;
            if (num / den > (BIGV >> fb)) return BIGV;
            r = (128'(num) << fb) / 128'(den);
            return r[63:0];
        endfunction

        function longint unsigned log2q(longint unsigned x);
            int n;
            longint unsigned m, frac;
            n = 0;
            frac = 0;
            x &= 64'h7FFF_FFFF;
            if (x == 0) return 0;
            for (longint unsigned t = x; t > 1; t >>= 1) n++;
            m = x << (30 - n);
            for (int i = 0; i < 28; i++) begin
                m = (m * m) >> 30;
                frac <<= 1;
                if (m >= (64'd1 << 31)) begin
                    frac |= 1;
                    m >>= 1;
                end
            end
            return (longint'(n) << 28) | frac;
        endfunction

        function logic [47:0] enc(longint unsigned mag, bit neg);
            longint unsigned m;
            m = mag > 64'h7FFF_FFFF_FFFF ? 64'h7FFF_FFFF_FFFF : mag;
            return neg ? 48'(-m) : 48'(m);
        endfunction

        // predict the result for one accepted item
        function void note_item(logic cmd, logic signed [31:0] a, logic signed [31:0] b,
                                logic f1, logic f2);
            term_t r;
            longint e, dr, ad;
            longint unsigned d, en, tm, hm, g, le, ld, df, nl, q;
            bit act, err, fneg;
            e = longint'(eps);
            d = 0; en = 0; tm = 0; hm = 0;
            if (cmd == CMD_FLOOR) begin
                act = !f1 && longint'(a) <= e;
                err = act && a <= 0;
                if (act && !err) d = longint'(a);
                fneg = 1;
            end else begin
                dr = longint'(b) - longint'(a);
                ad = dr < 0 ? -dr : dr;
                act = !(f1 && f2) && ad < e;
                err = act && ad == 0;
                d = ad;
                fneg = dr < 0;
            end
            if (act && err) begin
                en = BIGV; tm = BIGV; hm = BIGV;
            end else if (act) begin
                g = eps - d;
                le = log2q(eps);
                ld = log2q(d);
                df = le > ld ? le - ld : 0;
                nl = (df * 744261118 + (64'd1 << 29)) >> 30;
                q = div_frac(g, d, 28);
                en = mul_shr(g * g, nl, 52);
                tm = mul_shr(g, sat_add(q, 2 * nl), 28);
                hm = sat_add(div_frac(g * (eps + 3 * d), d * d, 24), (nl + 4) >> 3);
            end
            r = '0;
            if (act) begin
                r.act = 1;
                r.err = err;
                r.en = enc(en, 0);
                r.g1 = enc(tm, fneg);
                r.g2 = (cmd == CMD_PAIR) ? enc(tm, !fneg) : 48'd0;
                r.hs = enc(hm, 0);
            end
            pending = {pending, r};
        endfunction

        function void report(string f, logic [47:0] xv, logic [47:0] gv);
            $display("%0t: %s expected %h actual %h", $time, f, xv, gv);
            errors++;
        endfunction

        function void check_result(term_t got);
            term_t x;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (x.act !== got.act) report("active", x.act, got.act);
            if (x.err !== got.err) report("range_error", x.err, got.err);
            if (x.en !== got.en) report("energy_term", x.en, got.en);
            if (x.g1 !== got.g1) report("grad_first", x.g1, got.g1);
            if (x.g2 !== got.g2) report("grad_second", x.g2, got.g2);
            if (x.hs !== got.hs) report("hess_term", x.hs, got.hs);
        endfunction
    endclass

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [EPS_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;

    barrier_board board = new();
    int  hold_cycles = 0;       // receiver hold-off countdown
    bit  hold_req = 0;          // long receiver hold-off request
    bit  hold_done = 0;

    always #5 aclk = ~aclk;

    log_barrier_term_eval u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // receiver: stall pattern plus one long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result({m_tuser[0], m_tuser[1], m_tdata[47:0], m_tdata[95:48],
                                m_tdata[143:96], m_tdata[191:144]});
        if (hold_req && !hold_done) begin
            hold_done   <= 1;
            hold_cycles <= 299;
            m_tready    <= 0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0) || (($time / 4000) % 3 == 0);
        end
    end

    task automatic send_item(logic cmd, logic [31:0] a, logic [31:0] b, logic f1, logic f2);
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= {f2, f1, b, a};
        do @(posedge aclk); while (!s_tready);
        board.note_item(cmd, a, b, f1, f2);
    endtask

    task automatic idle_sender(int n);
        s_tvalid <= 0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic write_eps(logic [30:0] v);
        wait_drained();
        repeat (PIPE_LAT + 5) @(posedge aclk);
        cfg_valid <= 1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        board.eps = v;
    endtask

    function automatic logic [31:0] rand_pos(longint unsigned e);
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, e[31:0] == 0 ? 1 : 32'(e));
            2: return 32'(e) + $urandom_range(0, 3) - 2;
            3: return $urandom_range(0, 16);
            default: return $urandom_range(0, 32'(e) + 32'(e) / 4 + 1);
        endcase
    endfunction

    task automatic random_items(int n, longint unsigned e);
        int burst;
        logic [31:0] a, d;
        logic cmd;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 8));
            end
            burst--;
            cmd = $urandom_range(0, 1);
            a = rand_pos(e);
            // pairs mostly near each other so d < e is common
            d = ($urandom_range(0, 4) == 0) ? $urandom() : rand_pos(e);
            if ($urandom_range(0, 1)) d = -d;
            send_item(cmd, cmd ? ($urandom_range(0, 3) == 0 ? $urandom() : a) : a,
                      cmd ? a + d : $urandom(), $urandom_range(0, 5) == 0,
                      $urandom_range(0, 2) == 0);
        end
    endtask

    // directed corner items for the current eps
    task automatic corner_items(logic [31:0] e);
        send_item(CMD_FLOOR, e, 0, 0, 0);              // d equal to e
        send_item(CMD_FLOOR, e + 1, 0, 0, 0);          // just outside
        send_item(CMD_FLOOR, 1, 0, 0, 0);              // smallest distance
        send_item(CMD_FLOOR, 0, 0, 0, 1);              // zero distance
        send_item(CMD_FLOOR, 32'h8000_0000, 32'hFFFF_FFFF, 0, 1);
        send_item(CMD_FLOOR, 32'h7FFF_FFFF, 0, 0, 0);
        send_item(CMD_FLOOR, e / 2, 0, 1, 0);          // fixed vertex
        send_item(CMD_PAIR, 32'h100, 32'h100, 0, 0);   // coincident pair
        send_item(CMD_PAIR, 32'h100, 32'h100 + e - 1, 0, 1);
        send_item(CMD_PAIR, 32'h100 + e - 1, 32'h100, 1, 0);
        send_item(CMD_PAIR, 0, e, 0, 0);               // d equal to e
        send_item(CMD_PAIR, 5, 9, 1, 1);               // both fixed
        send_item(CMD_PAIR, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        send_item(CMD_PAIR, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        send_item(CMD_PAIR, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        corner_items(32'd16777216);
        random_items(300, 16777216);

        // long receiver hold-off while items keep coming
        hold_req <= 1;
        random_items(150, 16777216);
        wait_drained();                      // sender pauses until all results are back

        write_eps(31'h7FFF_FFFF);
        corner_items(32'h7FFF_FFFF);
        random_items(300, 64'h7FFF_FFFF);
        write_eps(31'd1);
        corner_items(32'd1);
        random_items(200, 1);
        write_eps(31'd0);
        corner_items(32'd0);
        random_items(100, 0);
        write_eps(31'h0012_3457);
        random_items(250, 64'h0012_3457);
        write_eps(31'h4000_0000);
        random_items(200, 64'h4000_0000);

        wait_drained();
        repeat (PIPE_LAT + 20) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
